FILE: rtl/gprd_pkg.sv
// shared types, constants and decode functions for the gamepad report decoder
package gprd_pkg;

  localparam int unsigned REPORT_LEN = 8;
  localparam int unsigned POS_W      = $clog2(REPORT_LEN);
  localparam int unsigned BTN_W      = 14;
  localparam int unsigned ZONE_W     = 3;
  localparam int unsigned NUM_STICK  = 4;

  localparam logic [7:0] IDLE_PATTERN [REPORT_LEN] = '{
    8'h80, 8'h00, 8'h00, 8'h40, 8'h40, 8'h40, 8'h40, 8'h00
  };

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(REPORT_LEN - 1);

  // byte 2 start/select codes
  localparam logic [7:0] CODE_START        = 8'h03;
  localparam logic [7:0] CODE_START_RIGHT  = 8'h07;
  localparam logic [7:0] CODE_START_LEFT   = 8'h0b;
  localparam logic [7:0] CODE_SELECT       = 8'h0c;
  localparam logic [7:0] CODE_SELECT_UP    = 8'h0d;
  localparam logic [7:0] CODE_SELECT_DOWN  = 8'h0e;

  localparam logic [BTN_W-1:0] BTN_START  = BTN_W'(14'h0001);
  localparam logic [BTN_W-1:0] BTN_SELECT = BTN_W'(14'h0002);
  localparam logic [BTN_W-1:0] BTN_UP     = BTN_W'(14'h0004);
  localparam logic [BTN_W-1:0] BTN_DOWN   = BTN_W'(14'h0008);
  localparam logic [BTN_W-1:0] BTN_RIGHT  = BTN_W'(14'h0010);
  localparam logic [BTN_W-1:0] BTN_LEFT   = BTN_W'(14'h0020);

  // stick thresholds
  localparam logic [7:0] STICK_NEUTRAL  = 8'h40;
  localparam logic [7:0] POS_HIGH_MIN   = 8'h71;
  localparam logic [7:0] POS_MID_MIN    = 8'h61;
  localparam logic [7:0] POS_LOW_MIN    = 8'h41;
  localparam logic [7:0] NEG_LOW_MIN    = 8'h20;
  localparam logic [7:0] NEG_MID_MIN    = 8'h10;

  localparam logic [ZONE_W-1:0] ZONE_NEUTRAL  = 3'd0;
  localparam logic [ZONE_W-1:0] ZONE_NEG_LOW  = 3'd1;
  localparam logic [ZONE_W-1:0] ZONE_NEG_MID  = 3'd2;
  localparam logic [ZONE_W-1:0] ZONE_NEG_HIGH = 3'd3;
  localparam logic [ZONE_W-1:0] ZONE_POS_LOW  = 3'd4;
  localparam logic [ZONE_W-1:0] ZONE_POS_MID  = 3'd5;
  localparam logic [ZONE_W-1:0] ZONE_POS_HIGH = 3'd6;

  typedef logic [NUM_STICK-1:0][ZONE_W-1:0] zones_t;

  // one complete report as passed from the collector to the decoder
  typedef struct packed {
    logic                      idle;
    logic [7:0]                btn_lo;
    logic [7:0]                btn_hi;
    logic [NUM_STICK-1:0][7:0] stick;
  } report_t;

  function automatic logic [ZONE_W-1:0] zone_of(input logic [7:0] b,
                                                input logic [ZONE_W-1:0] prev);
    logic [ZONE_W-1:0] z;
    if (b == STICK_NEUTRAL) begin
      z = ZONE_NEUTRAL;
    end else if (b[7]) begin
      z = prev;
    end else if (b >= POS_HIGH_MIN) begin
      z = ZONE_POS_HIGH;
    end else if (b >= POS_MID_MIN) begin
      z = ZONE_POS_MID;
    end else if (b >= POS_LOW_MIN) begin
      z = ZONE_POS_LOW;
    end else if (b >= NEG_LOW_MIN) begin
      z = ZONE_NEG_LOW;
    end else if (b >= NEG_MID_MIN) begin
      z = ZONE_NEG_MID;
    end else begin
      z = ZONE_NEG_HIGH;
    end
    return z;
  endfunction

  function automatic logic [BTN_W-1:0] decode_buttons(input logic [7:0] b1,
                                                      input logic [7:0] b2);
    logic [BTN_W-1:0] v;
    case (b2)
      CODE_START:       v = BTN_START;
      CODE_START_RIGHT: v = BTN_START | BTN_RIGHT;
      CODE_START_LEFT:  v = BTN_START | BTN_LEFT;
      CODE_SELECT:      v = BTN_SELECT;
      CODE_SELECT_UP:   v = BTN_SELECT | BTN_UP;
      CODE_SELECT_DOWN: v = BTN_SELECT | BTN_DOWN;
      default:          v = {8'h00, b2[3:0], 2'b00};
    endcase
    v[8:6]  = b2[6:4];
    v[13:9] = b1[4:0];
    return v;
  endfunction

endpackage

FILE: rtl/gprd_if.sv
// valid/ready channel interfaces for received bytes and decoded reports
interface gprd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface gprd_res_if;
  logic        valid;
  logic        ready;
  logic        idle_report;
  logic [13:0] buttons;
  logic [2:0]  left_x_zone;
  logic [2:0]  left_y_zone;
  logic [2:0]  right_x_zone;
  logic [2:0]  right_y_zone;
  logic [7:0]  raw_left_x;
  logic [7:0]  raw_left_y;
  logic [7:0]  raw_right_x;
  logic [7:0]  raw_right_y;

  modport source (output valid, output idle_report, output buttons,
                  output left_x_zone, output left_y_zone,
                  output right_x_zone, output right_y_zone,
                  output raw_left_x, output raw_left_y,
                  output raw_right_x, output raw_right_y,
                  input ready);
  modport sink   (input valid, input idle_report, input buttons,
                  input left_x_zone, input left_y_zone,
                  input right_x_zone, input right_y_zone,
                  input raw_left_x, input raw_left_y,
                  input raw_right_x, input raw_right_y,
                  output ready);
endinterface

FILE: rtl/gprd_collect.sv
// byte collector: counts report position, gathers bytes, tracks idle match
module gprd_collect
  import gprd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  gprd_rx_if.sink       rx,
  output logic          rpt_valid,
  input  logic          rpt_ready,
  output report_t       rpt
);

  logic [POS_W-1:0] pos;
  logic [7:0]       report_bytes [1:6];
  logic             idle_ok;
  logic             match;
  logic             accept;
  logic             last;

  assign match  = (rx.rx_byte == IDLE_PATTERN[pos]);
  assign last   = (pos == LAST_POS);
  // only the closing byte needs a free report slot
  assign rx.ready = !(last && rpt_valid && !rpt_ready);
  assign accept   = rx.valid && rx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      idle_ok   <= 1'b1;
      rpt_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (last) begin
          pos       <= '0;
          idle_ok   <= 1'b1;
        end else begin
          pos     <= pos + 1'b1;
          idle_ok <= (pos == '0) ? match : (idle_ok && match);
        end
      end
      if (accept && last) begin
        rpt_valid <= 1'b1;
      end else if (rpt_valid && rpt_ready) begin
        rpt_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && pos >= POS_W'(1) && pos <= POS_W'(6)) begin
      report_bytes[pos] <= rx.rx_byte;
    end
    if (accept && last) begin
      rpt.idle   <= idle_ok && match;
      rpt.btn_lo <= report_bytes[1];
      rpt.btn_hi <= report_bytes[2];
      rpt.stick  <= {report_bytes[6], report_bytes[5], report_bytes[4], report_bytes[3]};
    end
  end

`ifndef ASSERT_OFF
  a_last_wraps: assert property (@(posedge clk) disable iff (rst)
    accept && last |=> pos == '0 && rpt_valid)
    else $error("closing byte did not complete a report");
  a_rpt_holds: assert property (@(posedge clk) disable iff (rst)
    rpt_valid && !rpt_ready |=> rpt_valid && $stable(rpt))
    else $error("pending report changed before it was taken");
`endif

endmodule

FILE: rtl/gprd_decode.sv
// report decoder: buttons, stick zones with hold, result register
module gprd_decode
  import gprd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          rpt_valid,
  output logic          rpt_ready,
  input  report_t       rpt,
  gprd_res_if.source    res
);

  zones_t           held;
  zones_t           held_next;
  logic             out_valid;
  logic             idle_r;
  logic [BTN_W-1:0] buttons_r;
  zones_t           zones_r;
  logic [NUM_STICK-1:0][7:0] raw_r;
  logic             take;

  assign rpt_ready = !out_valid || res.ready;
  assign take      = rpt_valid && rpt_ready;

  always_comb begin
    for (int i = 0; i < NUM_STICK; i++) begin
      held_next[i] = zone_of(rpt.stick[i], held[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      held      <= '0;
    end else begin
      if (take) begin
        out_valid <= 1'b1;
        // an idle report leaves the held zones alone
        if (!rpt.idle) begin
          held <= held_next;
        end
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      idle_r    <= rpt.idle;
      buttons_r <= rpt.idle ? '0 : decode_buttons(rpt.btn_lo, rpt.btn_hi);
      zones_r   <= rpt.idle ? '0 : held_next;
      raw_r     <= rpt.stick;
    end
  end

  assign res.valid        = out_valid;
  assign res.idle_report  = idle_r;
  assign res.buttons      = buttons_r;
  assign res.left_x_zone  = zones_r[0];
  assign res.left_y_zone  = zones_r[1];
  assign res.right_x_zone = zones_r[2];
  assign res.right_y_zone = zones_r[3];
  assign res.raw_left_x   = raw_r[0];
  assign res.raw_left_y   = raw_r[1];
  assign res.raw_right_x  = raw_r[2];
  assign res.raw_right_y  = raw_r[3];

`ifndef ASSERT_OFF
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.idle_report |-> res.buttons == '0 && zones_r == '0)
    else $error("idle result carries buttons or zones");
  a_idle_keeps_held: assert property (@(posedge clk) disable iff (rst)
    take && rpt.idle |=> $stable(held))
    else $error("idle report disturbed the held zones");
  a_zone_tracks_held: assert property (@(posedge clk) disable iff (rst)
    take && !rpt.idle |=> zones_r == held)
    else $error("reported zones differ from held zones");
`endif

endmodule

FILE: rtl/gamepad_report_decoder.sv
// top level of the gamepad report decoder
// Takes one received byte per cycle on rx and groups bytes into eight-byte
// reports counted from reset, with no resynchronisation. Each eighth byte
// closes a report, which passes to res through the report register of the
// collector and then the result register of the decoder. Bytes are accepted
// every cycle; rx stalls only when a closing byte arrives while both
// registers still hold untaken work. An idle-pattern report gives
// idle_report with buttons and zones zero and leaves the held stick zones
// as they were; raw stick bytes are always passed out.
module gamepad_report_decoder
  import gprd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  gprd_rx_if.sink    rx,
  gprd_res_if.source res
);

  logic    rpt_valid;
  logic    rpt_ready;
  report_t rpt;

  gprd_collect u_collect (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .rpt_valid (rpt_valid),
    .rpt_ready (rpt_ready),
    .rpt       (rpt)
  );

  gprd_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .rpt_valid (rpt_valid),
    .rpt_ready (rpt_ready),
    .rpt       (rpt),
    .res       (res)
  );

endmodule

FILE: sim/tb.sv
// self-checking testbench for the gamepad report decoder
module tb;
  import gprd_pkg::*;

  typedef struct packed {
    logic                           idle;
    logic [BTN_W-1:0]               buttons;
    logic [NUM_STICK-1:0][ZONE_W-1:0] zones;
    logic [NUM_STICK-1:0][7:0]      raw;
  } decoded_report_t;

  typedef logic [7:0] report_frame_t [REPORT_LEN];

  typedef enum int {
    RPT_IDLE,
    RPT_NEAR_IDLE,
    RPT_NOISE,
    RPT_FORMED
  } report_kind_t;

  localparam logic [7:0] STICK_EDGES [13] = '{
    8'h00, 8'h0f, 8'h10, 8'h1f, 8'h20, 8'h3f, 8'h40,
    8'h41, 8'h60, 8'h61, 8'h70, 8'h71, 8'h7f
  };
  localparam logic [7:0] COMBO_CODES [6] = '{
    CODE_START, CODE_START_RIGHT, CODE_START_LEFT,
    CODE_SELECT, CODE_SELECT_UP, CODE_SELECT_DOWN
  };

  logic clk;
  logic rst;

  gprd_rx_if  rx_ch ();
  gprd_res_if res_ch ();

  gamepad_report_decoder u_dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .res (res_ch)
  );

  // decoder state as the testbench sees it
  logic [POS_W-1:0]  rpt_pos;
  logic [7:0]        rpt_bytes [0:6];
  logic              idle_so_far;
  logic [ZONE_W-1:0] held_zone [NUM_STICK];

  decoded_report_t pending_reports [$];
  int  mismatches  = 0;
  int  stall_left  = 0;
  bit  sink_stalls = 1'b0;
  bit  src_gaps    = 1'b0;

  initial begin
    clk = 1'b0;
  end

  always #2 clk = ~clk;

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 3);
    end else if (r < 92) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ZONE_W-1:0] stick_zone(input logic [7:0] b,
                                                   input logic [ZONE_W-1:0] held);
    logic [ZONE_W-1:0] z;
    if (b == STICK_NEUTRAL) begin
      z = ZONE_NEUTRAL;
    end else if (b[7]) begin
      z = held;
    end else if (b > 8'h70) begin
      z = ZONE_POS_HIGH;
    end else if (b > 8'h60) begin
      z = ZONE_POS_MID;
    end else if (b > 8'h40) begin
      z = ZONE_POS_LOW;
    end else if (b > 8'h1f) begin
      z = ZONE_NEG_LOW;
    end else if (b > 8'h0f) begin
      z = ZONE_NEG_MID;
    end else begin
      z = ZONE_NEG_HIGH;
    end
    return z;
  endfunction

  function automatic logic [BTN_W-1:0] button_bits(input logic [7:0] b1,
                                                   input logic [7:0] b2);
    logic       start;
    logic       sel;
    logic [3:0] dpad;
    start = (b2 == CODE_START) || (b2 == CODE_START_RIGHT) || (b2 == CODE_START_LEFT);
    sel   = (b2 == CODE_SELECT) || (b2 == CODE_SELECT_UP) || (b2 == CODE_SELECT_DOWN);
    // d-pad order is left, right, down, up
    if (start || sel) begin
      dpad = {b2 == CODE_START_LEFT, b2 == CODE_START_RIGHT,
              b2 == CODE_SELECT_DOWN, b2 == CODE_SELECT_UP};
    end else begin
      dpad = b2[3:0];
    end
    return {b1[4:0], b2[6:4], dpad, sel, start};
  endfunction

  function automatic void take_byte(input logic [7:0] b);
    decoded_report_t e;
    logic            hit;
    hit = (b == IDLE_PATTERN[rpt_pos]);
    if (rpt_pos != LAST_POS) begin
      rpt_bytes[rpt_pos] = b;
      idle_so_far = (rpt_pos == '0) ? hit : (idle_so_far && hit);
      rpt_pos++;
    end else begin
      e.idle = idle_so_far && hit;
      for (int i = 0; i < NUM_STICK; i++) begin
        e.raw[i] = rpt_bytes[3 + i];
      end
      if (e.idle) begin
        // idle report leaves the held zones alone
        e.buttons = '0;
        e.zones   = '0;
      end else begin
        e.buttons = button_bits(rpt_bytes[1], rpt_bytes[2]);
        for (int i = 0; i < NUM_STICK; i++) begin
          held_zone[i] = stick_zone(rpt_bytes[3 + i], held_zone[i]);
          e.zones[i]   = held_zone[i];
        end
      end
      pending_reports.push_back(e);
      rpt_pos     = '0;
      idle_so_far = 1'b1;
    end
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    decoded_report_t e;
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (pending_reports.size() == 0) begin
        $error("report transfer with no report pending");
        mismatches++;
      end else begin
        e = pending_reports.pop_front();
        check_field("idle_report",  16'(e.idle),     16'(res_ch.idle_report));
        check_field("buttons",      16'(e.buttons),  16'(res_ch.buttons));
        check_field("left_x_zone",  16'(e.zones[0]), 16'(res_ch.left_x_zone));
        check_field("left_y_zone",  16'(e.zones[1]), 16'(res_ch.left_y_zone));
        check_field("right_x_zone", 16'(e.zones[2]), 16'(res_ch.right_x_zone));
        check_field("right_y_zone", 16'(e.zones[3]), 16'(res_ch.right_y_zone));
        check_field("raw_left_x",   16'(e.raw[0]),   16'(res_ch.raw_left_x));
        check_field("raw_left_y",   16'(e.raw[1]),   16'(res_ch.raw_left_y));
        check_field("raw_right_x",  16'(e.raw[2]),   16'(res_ch.raw_right_x));
        check_field("raw_right_y",  16'(e.raw[3]),   16'(res_ch.raw_right_y));
      end
    end
  end

  // back-pressure on the report side
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
      if (sink_stalls && $urandom_range(0, 3) == 0) begin
        stall_left <= pick_gap();
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int n;
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (rx_ch.ready !== 1'b1);
    take_byte(b);
    n = 0;
    if (src_gaps && $urandom_range(0, 2) == 0) begin
      n = pick_gap();
    end
    if (n > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_report(input report_frame_t f);
    for (int i = 0; i < REPORT_LEN; i++) begin
      send_byte(f[i]);
    end
  endtask

  function automatic logic [7:0] pick_stick();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      return STICK_EDGES[$urandom_range(0, 12)];
    end else if (r < 7) begin
      return 8'($urandom_range(8'h80, 8'hff));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_combo_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      return COMBO_CODES[$urandom_range(0, 5)];
    end else if (r < 5) begin
      // a combo code with upper bits set is not a combo
      return COMBO_CODES[$urandom_range(0, 5)] | 8'($urandom_range(1, 15) << 4);
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void build_report(input report_kind_t kind, output report_frame_t f);
    for (int i = 0; i < REPORT_LEN; i++) begin
      f[i] = IDLE_PATTERN[i];
    end
    case (kind)
      RPT_IDLE: ;
      RPT_NEAR_IDLE: begin
        f[$urandom_range(0, REPORT_LEN - 1)] = 8'($urandom_range(0, 255));
      end
      RPT_NOISE: begin
        for (int i = 0; i < REPORT_LEN; i++) begin
          f[i] = 8'($urandom_range(0, 255));
        end
      end
      default: begin
        if ($urandom_range(0, 3) == 0) begin
          f[0] = 8'($urandom_range(0, 255));
        end
        f[1] = 8'($urandom_range(0, 255));
        f[2] = pick_combo_byte();
        for (int i = 3; i < 7; i++) begin
          f[i] = pick_stick();
        end
        if ($urandom_range(0, 3) == 0) begin
          f[7] = 8'($urandom_range(0, 255));
        end
      end
    endcase
  endfunction

  function automatic report_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 19);
    if (r < 2) begin
      return RPT_IDLE;
    end else if (r < 4) begin
      return RPT_NEAR_IDLE;
    end else if (r < 6) begin
      return RPT_NOISE;
    end
    return RPT_FORMED;
  endfunction

  // extreme buttons and sticks, idle report between two held-zone reports
  task automatic test_directed();
    report_frame_t f;
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    f = '{8'h00, 8'hff, CODE_START, 8'h7f, 8'h00, 8'h71, 8'h70, 8'hff};
    send_report(f);
    build_report(RPT_IDLE, f);
    send_report(f);
    // sticks at 0x80 and 0xff hold the zones from before the idle report
    f = '{8'hff, 8'he0, 8'h8e, 8'h80, 8'hff, 8'h0f, 8'h20, 8'h00};
    send_report(f);
  endtask

  // full rate on both sides
  task automatic test_back_to_back();
    report_frame_t f;
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    repeat (50) begin
      build_report(pick_kind(), f);
      send_report(f);
    end
  endtask

  task automatic test_random_flow();
    report_frame_t f;
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    repeat (120) begin
      build_report(pick_kind(), f);
      send_report(f);
    end
  endtask

  // reports one byte away from idle, mixed with true idle ones
  task automatic test_near_idle();
    report_frame_t f;
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    repeat (45) begin
      build_report(($urandom_range(0, 3) == 0) ? RPT_IDLE : RPT_NEAR_IDLE, f);
      send_report(f);
    end
  endtask

  initial begin
    rst           = 1'b1;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = 8'h00;
    rpt_pos       = '0;
    idle_so_far   = 1'b1;
    for (int i = 0; i < 7; i++) begin
      rpt_bytes[i] = IDLE_PATTERN[i];
    end
    for (int i = 0; i < NUM_STICK; i++) begin
      held_zone[i] = ZONE_NEUTRAL;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_back_to_back();
    test_random_flow();
    test_near_idle();

    rx_ch.valid <= 1'b0;
    sink_stalls = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
